/* hw/rtl/occupancy_grid_closest_angle_update_macros.svh */
// Assertion helpers used by the grid update controller RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef OCCUPANCY_GRID_CLOSEST_ANGLE_UPDATE_MACROS_SVH
`define OCCUPANCY_GRID_CLOSEST_ANGLE_UPDATE_MACROS_SVH

// Same-cycle implication.
`define OGCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OGCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ogca_pkg.sv */
package ogca_pkg;

    localparam int POS_W   = 8;
    localparam int VALUE_W = 16;
    localparam int TAG_W   = 9;
    localparam int ANGLE_W = 11;
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int MAG_W   = ANGLE_W;

    localparam logic [TAG_W-1:0] FULL_TURN        = TAG_W'(360);
    localparam logic [TAG_W-1:0] ANGLE_WINDOW_RST = TAG_W'(30);

    typedef enum logic [1:0] {
        FUNC_ASSIGN = 2'd0,
        FUNC_ANGLE  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic calc;
        logic read;
        logic eval;
        logic clr;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

/* hw/rtl/ogca_datapath.sv */
module ogca_datapath #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ogca_pkg::t_dp_cmd             i_cmd,
    output ogca_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_wr_en,
    input  logic [ogca_pkg::TAG_W-1:0]    i_cfg_wr_data,
    input  logic [1:0]                    i_func,
    input  logic signed [ogca_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [ogca_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [ogca_pkg::VALUE_W-1:0] i_cell_value,
    input  logic [ogca_pkg::TAG_W-1:0]    i_sensor_tag,
    input  logic signed [ogca_pkg::ANGLE_W-1:0] i_angle_a,
    input  logic signed [ogca_pkg::ANGLE_W-1:0] i_angle_b,
    output logic                          o_updated,
    output logic                          o_cell_present,
    output logic signed [ogca_pkg::VALUE_W-1:0] o_read_value,
    output logic [ogca_pkg::TAG_W-1:0]    o_read_tag,
    output logic                          o_out_of_bounds
);
    import ogca_pkg::*;

    localparam int NCOLS  = GRID_WIDTH + 1;
    localparam int NROWS  = GRID_HEIGHT + 1;
    localparam int NCELLS = NCOLS * NROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CB     = $clog2(NCOLS);
    localparam int RB     = $clog2(NROWS);
    localparam int MB     = (CB > RB) ? CB : RB;
    localparam int PW     = ((MB > POS_W) ? MB : POS_W) + 2;
    localparam int MW     = 1 + TAG_W + VALUE_W;

    localparam logic [AW-1:0] NROWS_A   = AW'(NROWS);
    localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);

    // Input beat registers.
    t_func                     r_func;
    logic signed [POS_W-1:0]   r_px;
    logic signed [POS_W-1:0]   r_py;
    logic [VALUE_W-1:0]        r_val;
    logic [TAG_W-1:0]          r_tag;
    logic signed [DIFF_W-1:0]  r_diff;

    // Address and angle stage.
    logic [AW-1:0]             r_addr;
    logic                      r_oob;
    logic                      r_win_ok;
    logic [TAG_W-1:0]          r_closest;

    logic [MW-1:0]             r_rdata;
    logic [MW-1:0]             r_mem [NCELLS];

    logic [TAG_W-1:0]          r_angle_window;
    logic [AW-1:0]             r_clr_addr;

    // Coordinate mapping.
    logic signed [PW-1:0]      n_col_s;
    logic signed [PW-1:0]      n_row_s;
    logic                      n_oob;
    logic [AW-1:0]             n_addr;

    // Angular distance.
    logic [MAG_W-1:0]          n_mag;
    logic [MAG_W-1:0]          n_mag1;
    logic [MAG_W-1:0]          n_mag2;
    logic [MAG_W-1:0]          n_mag3;
    logic [TAG_W-1:0]          n_cw;
    logic [TAG_W-1:0]          n_ccw;

    // Evaluation.
    logic                      rd_valid;
    logic [TAG_W-1:0]          rd_tag;
    logic [VALUE_W-1:0]        rd_value;
    logic                      n_wr;
    logic [TAG_W-1:0]          n_wr_tag;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [MW-1:0]             mem_wdata;

    assign n_col_s = {{(PW-POS_W){r_px[POS_W-1]}}, r_px} + PW'(GRID_WIDTH / 2);
    assign n_row_s = PW'(GRID_HEIGHT / 2) - {{(PW-POS_W){r_py[POS_W-1]}}, r_py};

    assign n_oob = n_col_s[PW-1] || (n_col_s[PW-2:0] > (PW-1)'(GRID_WIDTH))
                || n_row_s[PW-1] || (n_row_s[PW-2:0] > (PW-1)'(GRID_HEIGHT));

    assign n_addr = AW'(AW'(n_col_s[CB-1:0]) * NROWS_A) + AW'(n_row_s[RB-1:0]);

    // The magnitude, truncated to MAG_W bits, is under six turns, so conditional
    // subtractions of four, two and one turn bring it into one turn.
    assign n_mag  = r_diff[DIFF_W-1] ? MAG_W'(-r_diff) : MAG_W'(r_diff);
    assign n_mag1 = (n_mag >= MAG_W'(4 * FULL_TURN)) ? n_mag - MAG_W'(4 * FULL_TURN) : n_mag;
    assign n_mag2 = (n_mag1 >= MAG_W'(2 * FULL_TURN)) ? n_mag1 - MAG_W'(2 * FULL_TURN) : n_mag1;
    assign n_mag3 = (n_mag2 >= MAG_W'(FULL_TURN)) ? n_mag2 - MAG_W'(FULL_TURN) : n_mag2;
    assign n_cw   = n_mag3[TAG_W-1:0];
    assign n_ccw  = FULL_TURN - n_cw;

    assign rd_valid = r_rdata[MW-1];
    assign rd_tag   = r_rdata[VALUE_W +: TAG_W];
    assign rd_value = r_rdata[VALUE_W-1:0];

    always_comb begin
        n_wr     = 1'b0;
        n_wr_tag = r_tag;
        if (!r_oob) begin
            unique case (r_func)
                FUNC_ASSIGN: begin
                    n_wr     = 1'b1;
                    n_wr_tag = r_tag;
                end
                FUNC_ANGLE: begin
                    n_wr     = r_win_ok && (!rd_valid || (rd_tag > r_closest));
                    n_wr_tag = r_closest;
                end
                FUNC_READ, FUNC_NOP: begin
                    n_wr     = 1'b0;
                    n_wr_tag = r_tag;
                end
                default: begin
                    n_wr     = 1'b0;
                    n_wr_tag = r_tag;
                end
            endcase
        end
    end

    assign mem_we    = i_cmd.clr || (i_cmd.eval && n_wr);
    assign mem_waddr = i_cmd.clr ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clr ? '0 : {1'b1, n_wr_tag, r_val};

    assign o_sts.clr_last = (r_clr_addr == LAST_CELL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_window <= ANGLE_WINDOW_RST;
            r_clr_addr     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_angle_window <= i_cfg_wr_data;
            end
            if (i_cmd.clr && !o_sts.clr_last) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_val  <= i_cell_value;
            r_tag  <= i_sensor_tag;
            r_diff <= {i_angle_a[ANGLE_W-1], i_angle_a} - {i_angle_b[ANGLE_W-1], i_angle_b};
        end
        if (i_cmd.calc) begin
            r_addr    <= n_addr;
            r_oob     <= n_oob;
            r_win_ok  <= (n_cw <= r_angle_window) || (n_ccw <= r_angle_window);
            r_closest <= (n_cw < n_ccw) ? n_cw : n_ccw;
        end
        if (i_cmd.eval) begin
            o_updated       <= n_wr;
            o_out_of_bounds <= r_oob;
            if (!r_oob && (r_func == FUNC_READ) && rd_valid) begin
                o_cell_present <= 1'b1;
                o_read_value   <= rd_value;
                o_read_tag     <= rd_tag;
            end else begin
                o_cell_present <= 1'b0;
                o_read_value   <= '0;
                o_read_tag     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rdata <= r_mem[r_addr];
        end
    end

endmodule

/* hw/rtl/ogca_ctrl.sv */
`include "occupancy_grid_closest_angle_update_macros.svh"

module ogca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ogca_pkg::t_dp_cmd o_cmd,
    input  ogca_pkg::t_dp_sts i_sts
);
    import ogca_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_EVAL
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.clr  = (r_state == ST_CLEAR);
    assign o_cmd.load = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.calc = (r_state == ST_CALC);
    assign o_cmd.read = (r_state == ST_READ);
    // The result register may be refilled in the same cycle its beat leaves.
    assign o_cmd.eval = (r_state == ST_EVAL) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.eval) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (o_cmd.eval) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    `OGCA_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({o_cmd.load, o_cmd.calc, o_cmd.read, o_cmd.eval, o_cmd.clr}), "more than one datapath command")
    `OGCA_ASSERT_NOW(a_eval_room, o_cmd.eval, (!r_out_valid || !i_out_stall), "result overwritten while stalled")
    `OGCA_ASSERT_NEXT(a_eval_shows, o_cmd.eval, r_out_valid, "evaluated result not presented")
    `OGCA_ASSERT_NEXT(a_load_calc, o_cmd.load, o_cmd.calc, "accepted beat not followed by address stage")

endmodule

/* hw/rtl/occupancy_grid_closest_angle_update.sv */
// Each input beat is accepted in idle, then passes the address and angle, memory read and
// evaluate/write states before its result is presented; no further beat is accepted until
// then. A stalled result lets the next beat in but holds it in evaluate until it leaves.
// Reset: synchronous, active low; afterwards a clearing pass writes every one of the
// (GRID_WIDTH+1)*(GRID_HEIGHT+1) memory cells (16641 at defaults), with no input accepted meanwhile.
// The angle window resets to 30 and may be written at any time.
module occupancy_grid_closest_angle_update #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ogca_pkg::TAG_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_func,
    input  logic signed [ogca_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [ogca_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [ogca_pkg::VALUE_W-1:0] i_cell_value,
    input  logic [ogca_pkg::TAG_W-1:0]          i_sensor_tag,
    input  logic signed [ogca_pkg::ANGLE_W-1:0] i_angle_a,
    input  logic signed [ogca_pkg::ANGLE_W-1:0] i_angle_b,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_updated,
    output logic                                o_cell_present,
    output logic signed [ogca_pkg::VALUE_W-1:0] o_read_value,
    output logic [ogca_pkg::TAG_W-1:0]          o_read_tag,
    output logic                                o_out_of_bounds
);
    import ogca_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    ogca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ogca_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_func          (i_func),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_cell_value    (i_cell_value),
        .i_sensor_tag    (i_sensor_tag),
        .i_angle_a       (i_angle_a),
        .i_angle_b       (i_angle_b),
        .o_updated       (o_updated),
        .o_cell_present  (o_cell_present),
        .o_read_value    (o_read_value),
        .o_read_tag      (o_read_tag),
        .o_out_of_bounds (o_out_of_bounds)
    );

endmodule
